// File: rtl/gps_pkg.sv
// shared types, constants and functions for the granular pitch shifter
`timescale 1ns / 1ps

package gps_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int WORD_BITS          = 2 * SAMPLE_BITS;
    localparam int RATE_FRAC_BITS     = 16;
    localparam int READ_BITS          = 28;
    localparam int IPART_BITS         = READ_BITS - RATE_FRAC_BITS;
    localparam int SCALE_BITS         = 24;
    localparam int PHASE_BITS         = RATE_FRAC_BITS + SCALE_BITS;
    localparam int ENV_BITS           = 24;
    localparam int ENV_FRAC_BITS      = 23;
    localparam int GLEN_BITS          = 13;
    localparam int HOP_BITS           = 15;
    localparam int HOP_COUNT_BITS     = 14;
    localparam int RATE_BITS          = 18;
    localparam int LIMIT_BITS         = GLEN_BITS + RATE_FRAC_BITS;
    localparam int MUL_A_BITS         = READ_BITS + 1;
    localparam int MUL_B_BITS         = SCALE_BITS + 1;
    localparam int MUL_P_BITS         = MUL_A_BITS + MUL_B_BITS;
    localparam int CFG_INDEX_BITS     = 3;
    localparam int CFG_DATA_BITS      = 24;
    localparam int DEF_BUFFER_DEPTH   = 4096;
    localparam int DEF_ENV_TABLE_BITS = 10;

    localparam logic [HOP_BITS-1:0] HOP_MAX = HOP_BITS'(16384);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE     = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_GRAIN_SIZE = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_HOP_SIZE   = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE       = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ENV_SCALE  = 3'd4;

    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] ENV_ONE = 64'd1 << ENV_FRAC_BITS;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RD0,
        ST_RD1,
        ST_IL,
        ST_IR,
        ST_BL,
        ST_BR,
        ST_FIN,
        ST_DONE
    } gps_state_t;

    typedef struct packed {
        logic                  enable;
        logic [GLEN_BITS-1:0]  glen;
        logic [HOP_BITS-1:0]   hop;
        logic [RATE_BITS-1:0]  rate;
        logic [SCALE_BITS-1:0] env_scale;
    } cfg_t;

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [SAMPLE_BITS+1:0] v
    );
        if (v > SAMPLE_MAX)
        begin
            return SAMPLE_MAX;
        end
        else if (v < SAMPLE_MIN)
        begin
            return SAMPLE_MIN;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // sin^2 by integer taylor series in q2.30, evaluated at elaboration
    function automatic logic [ENV_BITS-1:0] hann_entry(
        input int unsigned k,
        input int unsigned tb
    );
        logic [63:0] full;
        logic [63:0] kk;
        logic [63:0] t;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] p;
        logic [63:0] s;
        logic [63:0] e;
        full = 64'd1 << tb;
        kk   = 64'(k);
        t    = (kk < full - kk) ? kk : full - kk;
        a    = (t * PI_Q30) >> tb;
        a2   = (a * a) >> 30;
        p    = ONE_Q30;
        p    = ONE_Q30 - ((a2 * p) >> 30) / 64'd110;
        p    = ONE_Q30 - ((a2 * p) >> 30) / 64'd72;
        p    = ONE_Q30 - ((a2 * p) >> 30) / 64'd42;
        p    = ONE_Q30 - ((a2 * p) >> 30) / 64'd20;
        p    = ONE_Q30 - ((a2 * p) >> 30) / 64'd6;
        s    = (a * p) >> 30;
        if (s > ONE_Q30)
        begin
            s = ONE_Q30;
        end
        e = (s * s + (64'd1 << 36)) >> 37;
        if (e > ENV_ONE)
        begin
            e = ENV_ONE;
        end
        return e[ENV_BITS-1:0];
    endfunction

endpackage

// File: rtl/gps_cfg_regs.sv
// configuration registers with range clamping of grain and hop length
`timescale 1ns / 1ps

module gps_cfg_regs #(
    parameter int BUFFER_DEPTH = gps_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [gps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output gps_pkg::cfg_t                      cfg
);
    import gps_pkg::*;

    logic                  enable_reg;
    logic [GLEN_BITS-1:0]  grain_size_reg;
    logic [HOP_BITS-1:0]   hop_size_reg;
    logic [RATE_BITS-1:0]  rate_reg;
    logic [SCALE_BITS-1:0] env_scale_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            grain_size_reg <= GLEN_BITS'(1440);
            hop_size_reg   <= HOP_BITS'(64);
            rate_reg       <= RATE_BITS'(65536);
            env_scale_reg  <= SCALE_BITS'(11651);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_ENABLE:     enable_reg     <= cfg_data[0];
                CFG_GRAIN_SIZE: grain_size_reg <= cfg_data[GLEN_BITS-1:0];
                CFG_HOP_SIZE:   hop_size_reg   <= cfg_data[HOP_BITS-1:0];
                CFG_RATE:       rate_reg       <= cfg_data[RATE_BITS-1:0];
                CFG_ENV_SCALE:  env_scale_reg  <= cfg_data[SCALE_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        cfg.enable    = enable_reg;
        cfg.rate      = rate_reg;
        cfg.env_scale = env_scale_reg;
        if (grain_size_reg == '0)
        begin
            cfg.glen = GLEN_BITS'(1);
        end
        else if (32'(grain_size_reg) > 32'(BUFFER_DEPTH))
        begin
            cfg.glen = GLEN_BITS'(BUFFER_DEPTH);
        end
        else
        begin
            cfg.glen = grain_size_reg;
        end
        if (hop_size_reg == '0)
        begin
            cfg.hop = HOP_BITS'(1);
        end
        else if (hop_size_reg > HOP_MAX)
        begin
            cfg.hop = HOP_MAX;
        end
        else
        begin
            cfg.hop = hop_size_reg;
        end
    end

endmodule

// File: rtl/gps_grain_mem.sv
// circular grain store, one write port and one registered read port
`timescale 1ns / 1ps

module gps_grain_mem #(
    parameter int DEPTH = gps_pkg::DEF_BUFFER_DEPTH
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  logic [gps_pkg::WORD_BITS-1:0] wdata,
    input  logic                          re,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output logic [gps_pkg::WORD_BITS-1:0] rdata
);
    import gps_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/gps_env_rom.sv
// raised-cosine envelope rom with registered read
`timescale 1ns / 1ps

module gps_env_rom #(
    parameter int TABLE_BITS = gps_pkg::DEF_ENV_TABLE_BITS
) (
    input  logic                         clk,
    input  logic                         re,
    input  logic [TABLE_BITS:0]          addr,
    output logic [gps_pkg::ENV_BITS-1:0] env
);
    import gps_pkg::*;

    localparam int ENTRIES = (1 << TABLE_BITS) + 1;

    logic [ENV_BITS-1:0] rom_w [ENTRIES];

    for (genvar k = 0; k < ENTRIES; k++)
    begin : g_rom
        assign rom_w[k] = hann_entry(k, TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            env <= rom_w[addr];
        end
    end

endmodule

// File: rtl/gps_mul.sv
// shared signed multiplier with registered product
`timescale 1ns / 1ps

module gps_mul (
    input  logic                                  clk,
    input  logic signed [gps_pkg::MUL_A_BITS-1:0] a,
    input  logic signed [gps_pkg::MUL_B_BITS-1:0] b,
    output logic signed [gps_pkg::MUL_P_BITS-1:0] prod
);
    import gps_pkg::*;

    always_ff @(posedge clk)
    begin
        prod <= MUL_P_BITS'(a) * MUL_P_BITS'(b);
    end

endmodule

// File: rtl/granular_pitch_shifter_top.sv
// top level: sequencer and datapath of the granular pitch shifter
`timescale 1ns / 1ps

// Stereo granular pitch shifter. Each input word carries one left/right pair; with
// enable set, the next pair is accepted only once the last one is finished, since
// a single multiplier computes the envelope phase, both interpolations and both
// blends in turn, and the one read port of the grain store fetches the two
// neighbouring entries on separate cycles. With enable clear a pair skips these
// steps. A stalled output holds the sequencer in its last state until the
// output register is free. A finished word waits in the output register while the
// next pair is accepted. The grain store reads as zero where it was never written,
// tracked by the write position and a wrap flag, so no clearing pass follows reset.
// BUFFER_DEPTH must be a power of two.
module granular_pitch_shifter_top #(
    parameter int BUFFER_DEPTH   = gps_pkg::DEF_BUFFER_DEPTH,
    parameter int ENV_TABLE_BITS = gps_pkg::DEF_ENV_TABLE_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [gps_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gps_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // in_left, in_right
    input  logic [gps_pkg::WORD_BITS-1:0]      s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // out_left, out_right
    output logic [gps_pkg::WORD_BITS-1:0]      m_axis_tdata
);
    import gps_pkg::*;

    localparam int ADDR_BITS = $clog2(BUFFER_DEPTH);
    localparam int IDX_BITS  = ENV_TABLE_BITS + 1;
    localparam int SUM_BITS  = ADDR_BITS + IPART_BITS + 1;

    cfg_t       cfg;
    gps_state_t state_reg;
    gps_state_t state_next;

    logic in_acc;
    logic mem_we;
    logic mem_re;
    logic rom_re;
    logic out_load;
    logic out_valid_reg;
    logic out_valid_next;
    logic [WORD_BITS-1:0] out_data_reg;

    logic [ADDR_BITS-1:0]      write_pos_reg;
    logic [ADDR_BITS-1:0]      origin_reg;
    logic [READ_BITS-1:0]      read_pos_reg;
    logic [HOP_COUNT_BITS-1:0] hop_count_reg;
    logic                      full_reg;

    logic signed [SAMPLE_BITS-1:0] x_l_reg;
    logic signed [SAMPLE_BITS-1:0] x_r_reg;
    logic signed [SAMPLE_BITS-1:0] s0_l_reg;
    logic signed [SAMPLE_BITS-1:0] s0_r_reg;
    logic signed [SAMPLE_BITS-1:0] s1_r_reg;
    logic signed [SAMPLE_BITS-1:0] g_l_reg;
    logic signed [SAMPLE_BITS-1:0] g_r_reg;
    logic signed [SAMPLE_BITS-1:0] y_l_reg;
    logic signed [SAMPLE_BITS-1:0] y_r_reg;
    logic [ADDR_BITS-1:0]          i0_reg;
    logic [ADDR_BITS-1:0]          i1_reg;
    logic                          v1_reg;
    logic [READ_BITS-1:0]          rp_sum_reg;
    logic [READ_BITS-1:0]          rp_next_reg;

    logic [WORD_BITS-1:0]   rd_data;
    logic [ENV_BITS-1:0]    env;
    logic [IDX_BITS-1:0]    eidx;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic [SUM_BITS-1:0]    idx_sum;
    logic [LIMIT_BITS-1:0]  limit;
    logic [HOP_BITS-1:0]    hop_inc;
    logic                   wp_last;

    logic signed [SAMPLE_BITS-1:0] s0_l_w;
    logic signed [SAMPLE_BITS-1:0] s0_r_w;
    logic signed [SAMPLE_BITS-1:0] s1_l_w;
    logic signed [SAMPLE_BITS-1:0] s1_r_w;
    logic signed [SAMPLE_BITS:0]   diff_w;
    logic signed [SAMPLE_BITS+1:0] g_sum;
    logic signed [SAMPLE_BITS+1:0] y_sum;

    logic signed [MUL_A_BITS-1:0] mul_a;
    logic signed [MUL_B_BITS-1:0] mul_b;
    logic signed [MUL_P_BITS-1:0] prod;

    gps_cfg_regs #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gps_grain_mem #(
        .DEPTH (BUFFER_DEPTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (write_pos_reg),
        .wdata ({x_r_reg, x_l_reg}),
        .re    (mem_re),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    gps_env_rom #(
        .TABLE_BITS (ENV_TABLE_BITS)
    ) u_rom (
        .clk  (clk),
        .re   (rom_re),
        .addr (eidx),
        .env  (env)
    );

    gps_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        rom_re         = 1'b0;
        out_load       = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = cfg.enable ? ST_WRITE : ST_DONE;
                end
            end
            ST_WRITE:
            begin
                mem_we     = 1'b1;
                state_next = ST_RD0;
            end
            ST_RD0:
            begin
                mem_re     = 1'b1;
                rom_re     = 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                mem_re     = 1'b1;
                state_next = ST_IL;
            end
            ST_IL:  state_next = ST_IR;
            ST_IR:  state_next = ST_BL;
            ST_BL:  state_next = ST_BR;
            ST_BR:  state_next = ST_FIN;
            ST_FIN: state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // store entries count as zero until written
    assign s0_l_w = (full_reg || (i0_reg <= write_pos_reg)) ? rd_data[SAMPLE_BITS-1:0] : '0;
    assign s0_r_w = (full_reg || (i0_reg <= write_pos_reg)) ?
                    rd_data[WORD_BITS-1:SAMPLE_BITS] : '0;
    assign s1_l_w = v1_reg ? rd_data[SAMPLE_BITS-1:0] : '0;
    assign s1_r_w = v1_reg ? rd_data[WORD_BITS-1:SAMPLE_BITS] : '0;

    assign rd_addr = (state_reg == ST_RD1) ? i1_reg : i0_reg;
    assign idx_sum = SUM_BITS'(origin_reg) + SUM_BITS'(read_pos_reg[READ_BITS-1:RATE_FRAC_BITS]);
    assign limit   = {cfg.glen, {RATE_FRAC_BITS{1'b0}}};
    assign hop_inc = HOP_BITS'(hop_count_reg) + HOP_BITS'(1);
    assign wp_last = (write_pos_reg == ADDR_BITS'(BUFFER_DEPTH - 1));

    always_comb
    begin
        if (|prod[MUL_P_BITS-1:PHASE_BITS])
        begin
            eidx = IDX_BITS'(1) << ENV_TABLE_BITS;
        end
        else
        begin
            eidx = {1'b0, prod[PHASE_BITS-1 -: ENV_TABLE_BITS]};
        end
    end

    always_comb
    begin
        diff_w = '0;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_WRITE:
            begin
                mul_a = $signed({1'b0, read_pos_reg});
                mul_b = $signed({1'b0, cfg.env_scale});
            end
            ST_IL:
            begin
                diff_w = (SAMPLE_BITS+1)'(s1_l_w) - (SAMPLE_BITS+1)'(s0_l_reg);
                mul_a  = MUL_A_BITS'(diff_w);
                mul_b  = $signed({{(MUL_B_BITS-RATE_FRAC_BITS){1'b0}},
                                  read_pos_reg[RATE_FRAC_BITS-1:0]});
            end
            ST_IR:
            begin
                diff_w = (SAMPLE_BITS+1)'(s1_r_reg) - (SAMPLE_BITS+1)'(s0_r_reg);
                mul_a  = MUL_A_BITS'(diff_w);
                mul_b  = $signed({{(MUL_B_BITS-RATE_FRAC_BITS){1'b0}},
                                  read_pos_reg[RATE_FRAC_BITS-1:0]});
            end
            ST_BL:
            begin
                diff_w = (SAMPLE_BITS+1)'(g_l_reg) - (SAMPLE_BITS+1)'(x_l_reg);
                mul_a  = MUL_A_BITS'(diff_w);
                mul_b  = $signed({{(MUL_B_BITS-ENV_BITS){1'b0}}, env});
            end
            ST_BR:
            begin
                diff_w = (SAMPLE_BITS+1)'(g_r_reg) - (SAMPLE_BITS+1)'(x_r_reg);
                mul_a  = MUL_A_BITS'(diff_w);
                mul_b  = $signed({{(MUL_B_BITS-ENV_BITS){1'b0}}, env});
            end
            default: ;
        endcase
    end

    always_comb
    begin
        g_sum = (SAMPLE_BITS+2)'((state_reg == ST_IR) ? s0_l_reg : s0_r_reg)
              + (SAMPLE_BITS+2)'(prod >>> RATE_FRAC_BITS);
        y_sum = (SAMPLE_BITS+2)'((state_reg == ST_BR) ? x_l_reg : x_r_reg)
              + (SAMPLE_BITS+2)'(prod >>> ENV_FRAC_BITS);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    x_l_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
                    x_r_reg <= s_axis_tdata[WORD_BITS-1:SAMPLE_BITS];
                    y_l_reg <= s_axis_tdata[SAMPLE_BITS-1:0];
                    y_r_reg <= s_axis_tdata[WORD_BITS-1:SAMPLE_BITS];
                end
            end
            ST_WRITE:
            begin
                i0_reg     <= idx_sum[ADDR_BITS-1:0];
                rp_sum_reg <= READ_BITS'(read_pos_reg + READ_BITS'(cfg.rate));
            end
            ST_RD0:
            begin
                i1_reg <= i0_reg + ADDR_BITS'(1);
                v1_reg <= full_reg || ((i0_reg + ADDR_BITS'(1)) <= write_pos_reg);
                if (LIMIT_BITS'(rp_sum_reg) >= limit)
                begin
                    rp_next_reg <= READ_BITS'(LIMIT_BITS'(rp_sum_reg) - limit);
                end
                else
                begin
                    rp_next_reg <= rp_sum_reg;
                end
            end
            ST_RD1:
            begin
                s0_l_reg <= s0_l_w;
                s0_r_reg <= s0_r_w;
            end
            ST_IL:
            begin
                s1_r_reg <= s1_r_w;
            end
            ST_IR:
            begin
                g_l_reg <= g_sum[SAMPLE_BITS-1:0];
            end
            ST_BL:
            begin
                g_r_reg <= g_sum[SAMPLE_BITS-1:0];
            end
            ST_BR:
            begin
                y_l_reg <= sat_sample(y_sum);
            end
            ST_FIN:
            begin
                y_r_reg <= sat_sample(y_sum);
            end
            default: ;
        endcase
        if (out_load)
        begin
            out_data_reg <= {y_r_reg, y_l_reg};
        end
    end

    // grain position state advances once per pair that takes the grain path
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_pos_reg <= '0;
            origin_reg    <= '0;
            read_pos_reg  <= '0;
            hop_count_reg <= '0;
            full_reg      <= 1'b0;
        end
        else if (state_reg == ST_FIN)
        begin
            read_pos_reg <= rp_next_reg;
            if (hop_count_reg == '0)
            begin
                origin_reg <= write_pos_reg;
            end
            if (wp_last)
            begin
                write_pos_reg <= '0;
                hop_count_reg <= '0;
                full_reg      <= 1'b1;
            end
            else
            begin
                write_pos_reg <= write_pos_reg + ADDR_BITS'(1);
                hop_count_reg <= (hop_inc >= cfg.hop) ? '0 : hop_inc[HOP_COUNT_BITS-1:0];
            end
        end
    end

endmodule

// File: rtl/gps_checker.sv
// port-level assertions for the granular pitch shifter, bound to the top level
`timescale 1ns / 1ps

module gps_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [gps_pkg::WORD_BITS-1:0] m_axis_tdata
);

    // a stalled output word keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    // a stalled output word keeps its data
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // the sequencer is busy right after taking a word
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after accept");

    // no result appears in the cycle after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result too early");

    // a new result only follows a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result without processing");

endmodule

bind granular_pitch_shifter_top gps_checker u_gps_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: tb/tb_top.sv
// self-checking stream testbench for the granular pitch shifter
`timescale 1ns / 1ps

module tb_top;

    import gps_pkg::*;

    localparam int DEPTH       = 4096;
    localparam int TABLE_BITS  = 10;
    localparam int ROM_ENTRIES = (1 << TABLE_BITS) + 1;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int IDLE_PCT    = 25;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS = 145;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] right;
        logic signed [SAMPLE_BITS-1:0] left;
    } pair_t;

    typedef struct {
        pair_t pair;
        bit    hold;
    } item_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;
    logic                      s_valid = 1'b0;
    logic                      s_axis_tready;
    logic [WORD_BITS-1:0]      s_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_ready = 1'b0;
    logic [WORD_BITS-1:0]      m_axis_tdata;

    // mirror of the block's settings and state
    logic                      en_reg = 1'b0;
    logic [12:0]               grain_reg = 13'd1440;
    logic [14:0]               hop_reg = 15'd64;
    logic [17:0]               rate_reg = 18'd65536;
    logic [23:0]               scale_reg = 24'd11651;
    logic signed [SAMPLE_BITS-1:0] store_left [DEPTH];
    logic signed [SAMPLE_BITS-1:0] store_right [DEPTH];
    int unsigned               wr_pos = 0;
    int unsigned               origin = 0;
    logic [27:0]               rd_pos = '0;
    int unsigned               hop_cnt = 0;
    logic [23:0]               hann_rom [ROM_ENTRIES];

    item_t                     pending_words [$];
    pair_t                     expected_pairs [$];
    pair_t                     in_flight;
    item_t                     next_item;
    int                        words_in = 0;
    int                        words_out = 0;
    int                        mismatches = 0;
    int                        quiet_cycles = 0;

    granular_pitch_shifter_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // sin^2(pi*k/1024) in q1.23 via truncated taylor series in q2.30
    function automatic logic [23:0] raised_cosine_at(input int unsigned k);
        longint unsigned divs [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        longint unsigned t;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned p;
        longint unsigned s;
        longint unsigned e;
        t  = (k < (1 << TABLE_BITS) - k) ? k : (1 << TABLE_BITS) - k;
        a  = (t * 64'd3373259426) >> TABLE_BITS;
        a2 = (a * a) >> 30;
        p  = 64'd1 << 30;
        for (int i = 0; i < 5; i++)
        begin
            p = (64'd1 << 30) - ((a2 * p) >> 30) / divs[i];
        end
        s = (a * p) >> 30;
        if (s > (64'd1 << 30))
        begin
            s = 64'd1 << 30;
        end
        e = (s * s + (64'd1 << 36)) >> 37;
        if (e > (64'd1 << 23))
        begin
            e = 64'd1 << 23;
        end
        return e[23:0];
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] clip24(input longint v);
        if (v > 64'sd8388607)
        begin
            return 24'sh7FFFFF;
        end
        if (v < -64'sd8388608)
        begin
            return 24'sh800000;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // one stereo pair through the grain path, advancing the mirrored state
    function automatic pair_t pitch_shift_pair(input pair_t x);
        pair_t           y;
        int unsigned     glen;
        int unsigned     hop;
        int unsigned     i0;
        int unsigned     i1;
        int unsigned     eidx;
        longint unsigned phase;
        longint unsigned limit;
        longint          frac;
        longint          env;
        longint          s0;
        longint          s1;
        longint          g;
        longint          xs;
        if (!en_reg)
        begin
            return x;
        end
        glen = (grain_reg == 0) ? 1 : grain_reg;
        if (glen > DEPTH)
        begin
            glen = DEPTH;
        end
        hop = (hop_reg == 0) ? 1 : hop_reg;
        if (hop > 16384)
        begin
            hop = 16384;
        end
        store_left[wr_pos]  = x.left;
        store_right[wr_pos] = x.right;

        i0   = (origin + (rd_pos >> RATE_FRAC_BITS)) % DEPTH;
        i1   = (i0 + 1) % DEPTH;
        frac = longint'({48'd0, rd_pos[15:0]});
        phase = longint'({36'd0, rd_pos}) * longint'({40'd0, scale_reg});
        if (phase > (64'd1 << 40))
        begin
            phase = 64'd1 << 40;
        end
        eidx = 32'(phase >> 30);
        if (eidx >= ROM_ENTRIES)
        begin
            eidx = ROM_ENTRIES - 1;
        end
        env = longint'({40'd0, hann_rom[eidx]});

        s0 = store_left[i0];
        s1 = store_left[i1];
        g  = s0 + (((s1 - s0) * frac) >>> RATE_FRAC_BITS);
        xs = x.left;
        y.left = clip24(xs + (((g - xs) * env) >>> 23));
        s0 = store_right[i0];
        s1 = store_right[i1];
        g  = s0 + (((s1 - s0) * frac) >>> RATE_FRAC_BITS);
        xs = x.right;
        y.right = clip24(xs + (((g - xs) * env) >>> 23));

        limit  = longint'(glen) << RATE_FRAC_BITS;
        rd_pos = rd_pos + 28'(rate_reg);
        if (longint'({36'd0, rd_pos}) >= limit)
        begin
            rd_pos = 28'(longint'({36'd0, rd_pos}) - limit);
        end

        if (hop_cnt == 0)
        begin
            origin = wr_pos;
        end
        hop_cnt++;
        if (hop_cnt >= hop)
        begin
            hop_cnt = 0;
        end
        wr_pos++;
        if (wr_pos >= DEPTH)
        begin
            wr_pos  = 0;
            hop_cnt = 0;
        end
        return y;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] random_sample();
        case ($urandom_range(15))
            0: return SAMPLE_MAX;
            1: return SAMPLE_MIN;
            2: return '0;
            3: return -24'sd1;
            4: return 24'($signed($urandom_range(510)) - 255);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic queue_pair(
        input logic signed [SAMPLE_BITS-1:0] l,
        input logic signed [SAMPLE_BITS-1:0] r,
        input bit                            hold
    );
        item_t it;
        it.pair.left  = l;
        it.pair.right = r;
        it.hold       = hold;
        pending_words.insert(pending_words.size(), it);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_BITS'(val);
        case (idx)
            CFG_ENABLE:     en_reg    = val[0];
            CFG_GRAIN_SIZE: grain_reg = 13'(val);
            CFG_HOP_SIZE:   hop_reg   = 15'(val);
            CFG_RATE:       rate_reg  = 18'(val);
            CFG_ENV_SCALE:  scale_reg = 24'(val);
            default: ;
        endcase
    endtask

    task automatic load_settings(
        input int unsigned en,
        input int unsigned glen,
        input int unsigned hop,
        input int unsigned rate,
        input int unsigned scale
    );
        write_reg(CFG_ENABLE, en);
        write_reg(CFG_GRAIN_SIZE, glen);
        write_reg(CFG_HOP_SIZE, hop);
        write_reg(CFG_RATE, rate);
        write_reg(CFG_ENV_SCALE, scale);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // wait until every queued word is through, then let the pipeline go quiet
    task automatic settle();
        while (pending_words.size() != 0 || s_valid || expected_pairs.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_valid <= 1'b0;
        end
        else
        begin
            if (s_valid && s_axis_tready)
            begin
                expected_pairs.insert(expected_pairs.size(), pitch_shift_pair(in_flight));
                words_in++;
            end
            if (!s_valid || s_axis_tready)
            begin
                if (pending_words.size() != 0
                    && !(pending_words[0].hold && expected_pairs.size() != 0)
                    && ((words_in >= 500 && words_in < 800)
                        || $urandom_range(99) >= IDLE_PCT))
                begin
                    next_item = pending_words.pop_front();
                    in_flight = next_item.pair;
                    s_tdata   <= next_item.pair;
                    s_valid   <= 1'b1;
                end
                else
                begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge clk)
    begin
        pair_t got;
        pair_t want;
        if (!rst_n)
        begin
            m_ready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_ready)
            begin
                got = m_axis_tdata;
                if (expected_pairs.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("unexpected word %0d: left %0d right %0d",
                                 words_out, got.left, got.right);
                    end
                end
                else
                begin
                    want = expected_pairs.pop_front();
                    if (got.left !== want.left || got.right !== want.right)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display({"mismatch word %0d: left exp %0d got %0d, ",
                                      "right exp %0d got %0d"},
                                     words_out, want.left, got.left, want.right, got.right);
                        end
                    end
                end
                words_out++;
            end
            m_ready <= (words_out >= 500 && words_out < 800)
                       || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((s_valid && s_axis_tready) || (m_axis_tvalid && m_ready) || cfg_wr_en)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int unsigned en;
        int unsigned glen;
        int unsigned geff;
        int unsigned hop;
        int unsigned rate;
        int unsigned scale;
        for (int k = 0; k < ROM_ENTRIES; k++)
        begin
            hann_rom[k] = raised_cosine_at(k);
        end
        for (int k = 0; k < DEPTH; k++)
        begin
            store_left[k]  = '0;
            store_right[k] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: pass-through
        queue_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_pair('0, -24'sd1, 1'b0);
        settle();

        // grain path with the remaining reset settings
        write_reg(CFG_ENABLE, 1);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        queue_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        queue_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        queue_pair(-24'sd1, '0, 1'b0);
        settle();

        // zero grain and hop clamp, rate beyond the grain, phase past one grain
        load_settings(1, 0, 0, 262143, 16777215);
        queue_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        queue_pair('0, '0, 1'b0);
        queue_pair(24'sd1, -24'sd2, 1'b0);
        settle();

        // oversized grain and hop clamp, half rate, smallest nonzero scale
        load_settings(1, 8191, 32767, 32768, 1);
        queue_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_pair(-24'sd1, 24'sd1, 1'b0);
        queue_pair('0, SAMPLE_MAX, 1'b0);
        settle();

        // largest legal grain and hop, double rate
        load_settings(1, 4096, 16384, 131072, 4096);
        queue_pair(SAMPLE_MAX, '0, 1'b0);
        queue_pair(SAMPLE_MIN, '0, 1'b0);
        queue_pair('0, SAMPLE_MIN, 1'b0);
        queue_pair(SAMPLE_MAX, SAMPLE_MAX, 1'b0);
        queue_pair(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        settle();

        // one-sample grain, unit hop, frozen read position, zero scale
        load_settings(1, 1, 1, 0, 0);
        queue_pair(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        queue_pair(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        queue_pair('0, -24'sd1, 1'b0);
        queue_pair(24'sd4194304, -24'sd4194304, 1'b0);
        settle();

        // random settings, a run of words under each
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            en = (ph % 9 == 8) ? 0 : 1;
            case ($urandom_range(4))
                0: glen = $urandom_range(1, 16);
                1: glen = $urandom_range(17, 256);
                2: glen = $urandom_range(257, 4096);
                3:
                begin
                    case ($urandom_range(5))
                        0: glen = 0;
                        1: glen = 1;
                        2: glen = 2;
                        3: glen = 4096;
                        4: glen = 4097;
                        default: glen = 8191;
                    endcase
                end
                default: glen = $urandom_range(1, 64);
            endcase
            case ($urandom_range(4))
                0: hop = $urandom_range(1, 64);
                1: hop = $urandom_range(1, 4096);
                2: hop = $urandom_range(0, 32767);
                3:
                begin
                    case ($urandom_range(4))
                        0: hop = 0;
                        1: hop = 1;
                        2: hop = 16384;
                        3: hop = 16385;
                        default: hop = 32767;
                    endcase
                end
                default: hop = $urandom_range(1, 300);
            endcase
            case ($urandom_range(5))
                0: rate = 65536;
                1: rate = $urandom_range(0, 262143);
                2: rate = ($urandom_range(1) != 0) ? 32768 : 131072;
                3: rate = ($urandom_range(1) != 0) ? 0 : 262143;
                default: rate = $urandom_range(32768, 131072);
            endcase
            geff = (glen == 0) ? 1 : ((glen > DEPTH) ? DEPTH : glen);
            case ($urandom_range(7))
                0: scale = $urandom_range(0, 16777215);
                1: scale = ($urandom_range(1) != 0) ? 1 : 16777215;
                default: scale = ((1 << 24) / geff > 16777215) ? 16777215 : (1 << 24) / geff;
            endcase
            load_settings(en, glen, hop, rate, scale);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                queue_pair(random_sample(), random_sample(), $urandom_range(99) == 0);
            end
            settle();
        end

        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: granular_pitch_shifter_top.f
rtl/gps_pkg.sv
rtl/gps_cfg_regs.sv
rtl/gps_grain_mem.sv
rtl/gps_env_rom.sv
rtl/gps_mul.sv
rtl/granular_pitch_shifter_top.sv
rtl/gps_checker.sv
tb/tb_top.sv
